/* hw/rtl/ascii_rgb_frame_parser_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASCII_RGB_FRAME_PARSER_CORE_MACROS_SVH
`define ASCII_RGB_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ARFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define ARFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define ARFP_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/arfp_pkg.sv */
package arfp_pkg;

    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [7:0] WEIGHT_100 = 8'd100;
    localparam logic [7:0] WEIGHT_10  = 8'd10;

    // Frame layout: marker + 3 digits, four times
    localparam int          FRAME_LEN   = 16;
    localparam logic [3:0]  LAST_POS    = 4'(FRAME_LEN - 1);
    localparam int          NUM_FIELDS  = 4;
    localparam int          FIELD_DIGITS = 3;
    localparam int          NUM_CHARS   = NUM_FIELDS * FIELD_DIGITS;

    // Frame queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Digit characters only; markers are reduced to the ok flag
    typedef struct packed {
        logic                      ok;
        logic [NUM_CHARS-1:0][7:0] chars;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // d1*100 + d2*10 + d3, all mod 256, digits unchecked
    function automatic logic [7:0] field_value(input logic [7:0] c0,
                                               input logic [7:0] c1,
                                               input logic [7:0] c2);
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] p0;
        logic [7:0] p1;
        d0 = c0 - DIGIT_BASE;
        d1 = c1 - DIGIT_BASE;
        d2 = c2 - DIGIT_BASE;
        p0 = 8'(d0 * WEIGHT_100);
        p1 = 8'(d1 * WEIGHT_10);
        return 8'(p0 + p1 + d2);
    endfunction

endpackage

/* hw/rtl/ascii_rgb_frame_parser_core.sv */
// ASCII RGB frame parser. Bytes enter on i_rx_byte, one item per cycle at
// most, and are gathered into 16-character frames "Rddd" "Gddd" "Bddd"
// "Bddd". An 'R' anywhere restarts the frame at position 0. The 16th byte
// of a frame yields exactly one result item; all other bytes yield none.
// The result carries o_format_ok (markers R, G, B, B in place) and the
// four kept levels; on a format error the previous levels are reported
// unchanged. Each level is d1*100 + d2*10 + d3 mod 256 with each digit
// taken as (byte - 48) mod 256, unchecked. o_lamp_on is low only when all
// four levels are zero. Throughput is one byte per cycle while the frame
// queue is not full: the assembler front end never waits on conversion.
// A completed frame enters the two-entry frame queue at the edge that
// takes the closing byte and then moves into the output register. The
// input stalls only when the output is held back and two complete frames
// are already queued, which needs the output stalled for well over a
// frame's worth of bytes.
module ascii_rgb_frame_parser_core import arfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_format_ok,
    output logic       o_lamp_on,
    output logic [7:0] o_red_level,
    output logic [7:0] o_green_level,
    output logic [7:0] o_blue_level,
    output logic [7:0] o_brightness_level
);

    // front end -> queue
    logic    push;
    t_frame  push_frame;
    // queue -> back end
    logic    pop;
    t_frame  head_frame;
    t_q_stat q_stat;

    // Front end: frame position tracking, character store, marker check.
    arfp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_rx_byte(i_rx_byte),
        .o_stall  (o_stall),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_frame  (push_frame)
    );

    // Completed frames wait here so either side can stall on its own.
    arfp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_frame(push_frame),
        .i_pop  (pop),
        .o_head (head_frame),
        .o_stat (q_stat)
    );

    // Back end: digit conversion, kept levels, output register.
    arfp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_frame           (head_frame),
        .i_q_stat          (q_stat),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_format_ok       (o_format_ok),
        .o_lamp_on         (o_lamp_on),
        .o_red_level       (o_red_level),
        .o_green_level     (o_green_level),
        .o_blue_level      (o_blue_level),
        .o_brightness_level(o_brightness_level)
    );

endmodule

/* hw/rtl/arfp_front.sv */
module arfp_front import arfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic [7:0] i_rx_byte,
    output logic    o_stall,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_frame  o_frame
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [3:0] wr_pos;
    logic       accept;
    logic       last;
    // position 15 is never stored: it is consumed straight from the input
    logic [7:0] r_buf [LAST_POS];

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign wr_pos  = (i_rx_byte == CHAR_R) ? 4'd0 : r_pos;
    assign last    = (wr_pos == LAST_POS);
    assign o_push  = accept && last;

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = last ? 4'd0 : 4'(wr_pos + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !last) begin
            r_buf[wr_pos] <= i_rx_byte;
        end
    end

    assign o_frame.ok = (r_buf[0] == CHAR_R) && (r_buf[4] == CHAR_G) &&
                        (r_buf[8] == CHAR_B) && (r_buf[12] == CHAR_B);

    // digit k sits at frame position k + k/3 + 1
    for (genvar k = 0; k < NUM_CHARS - 1; k++) begin : g_chars
        localparam int POS = k + k / FIELD_DIGITS + 1;
        assign o_frame.chars[k] = r_buf[POS];
    end
    assign o_frame.chars[NUM_CHARS-1] = i_rx_byte;

endmodule

/* hw/rtl/arfp_queue.sv */
module arfp_queue import arfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_frame  i_frame,
    input  logic    i_pop,
    output t_frame  o_head,
    output t_q_stat o_stat
);

    t_frame              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

/* hw/rtl/arfp_back.sv */
module arfp_back import arfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_frame     i_frame,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_format_ok,
    output logic       o_lamp_on,
    output logic [7:0] o_red_level,
    output logic [7:0] o_green_level,
    output logic [7:0] o_blue_level,
    output logic [7:0] o_brightness_level
);

    logic [NUM_FIELDS-1:0][7:0] fv;
    logic [NUM_FIELDS-1:0][7:0] r_kept;
    logic [NUM_FIELDS-1:0][7:0] n_kept;
    logic                       r_valid;
    logic                       n_valid;
    logic                       r_ok;
    logic                       r_lamp;

    for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_conv
        assign fv[f] = field_value(i_frame.chars[f*FIELD_DIGITS],
                                   i_frame.chars[f*FIELD_DIGITS+1],
                                   i_frame.chars[f*FIELD_DIGITS+2]);
    end

    // output slot free or being emptied this cycle
    assign o_pop = !i_q_stat.empty && (!r_valid || !i_stall);

    always_comb begin
        n_kept  = r_kept;
        n_valid = r_valid && i_stall;
        if (o_pop) begin
            n_valid = 1'b1;
            if (i_frame.ok) begin
                n_kept = fv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_kept  <= '0;
        end else begin
            r_valid <= n_valid;
            r_kept  <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok   <= i_frame.ok;
            r_lamp <= (n_kept != '0);
        end
    end

    assign o_valid            = r_valid;
    assign o_format_ok        = r_ok;
    assign o_lamp_on          = r_lamp;
    assign o_red_level        = r_kept[0];
    assign o_green_level      = r_kept[1];
    assign o_blue_level       = r_kept[2];
    assign o_brightness_level = r_kept[3];

endmodule

/* hw/rtl/arfp_checker.sv */
`include "ascii_rgb_frame_parser_core_macros.svh"

module arfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_format_ok,
    input logic       o_lamp_on,
    input logic [7:0] o_red_level,
    input logic [7:0] o_green_level,
    input logic [7:0] o_blue_level,
    input logic [7:0] o_brightness_level
);

    logic any_level;

    assign any_level = (o_red_level != 8'd0) || (o_green_level != 8'd0) ||
                       (o_blue_level != 8'd0) || (o_brightness_level != 8'd0);

    // nothing is shown straight after reset
    `ARFP_ASSERT_NEXT_ALWAYS(a_reset_idle, !i_rst_n, !o_valid, "result valid after reset")

    // a held result keeps its payload
    `ARFP_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_format_ok) && $stable(o_lamp_on) && $stable(o_red_level) && $stable(o_green_level) && $stable(o_blue_level) && $stable(o_brightness_level), "stalled result changed")

    // lamp flag follows the reported levels
    `ARFP_ASSERT_NOW(a_lamp, o_valid, o_lamp_on == any_level, "lamp flag disagrees with levels")

    // the byte side can only back up behind a held result
    `ARFP_ASSERT_NOW(a_stall_cause, !o_valid, !o_stall, "input stalled with output empty")

endmodule

bind ascii_rgb_frame_parser_core arfp_checker u_arfp_checker (.*);
